// File: src/jpt_pkg.sv
// Shared types and constants for the JSON pull tokenizer.
// Used by jpt_front, jpt_back and json_pull_tokenizer_core; no dependencies.
package jpt_pkg;

   localparam int MAX_NESTING_DEF   = 16;
   localparam int POSITION_BITS_DEF = 16;
   localparam int MAX_RESULTS       = 3;
   localparam int QUEUE_DEPTH       = 4;

   // event codes
   localparam logic [2:0] EV_OBJECT  = 3'd0;
   localparam logic [2:0] EV_ARRAY   = 3'd1;
   localparam logic [2:0] EV_STRING  = 3'd2;
   localparam logic [2:0] EV_SCALAR  = 3'd3;
   localparam logic [2:0] EV_CLOSE   = 3'd4;
   localparam logic [2:0] EV_END     = 3'd5;
   localparam logic [2:0] EV_INVALID = 3'd6;

   // characters
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;

   typedef enum logic [9:0] {
      PH_ROOT         = 10'b00_0000_0001,
      PH_ITEM         = 10'b00_0000_0010,
      PH_NAME_START   = 10'b00_0000_0100,
      PH_NAME_QUOTED  = 10'b00_0000_1000,
      PH_NAME_BARE    = 10'b00_0001_0000,
      PH_AFTER_NAME   = 10'b00_0010_0000,
      PH_VALUE_START  = 10'b00_0100_0000,
      PH_VALUE_QUOTED = 10'b00_1000_0000,
      PH_VALUE_BARE   = 10'b01_0000_0000,
      PH_AFTER_ROOT   = 10'b10_0000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic        has_name;
      logic [15:0] name_first;
      logic [15:0] name_past;
      logic [15:0] value_first;
      logic [15:0] value_past;
      logic [4:0]  level;
      logic        run_end;
   } rsp_type;

   // all events caused by one input byte
   typedef struct packed {
      logic [1:0]                    count;
      rsp_type [MAX_RESULTS-1:0]     evs;
   } group_type;

   function automatic logic is_ws(input logic [7:0] c);
      return c == CH_SPACE || c == CH_CR || c == CH_LF || c == CH_TAB;
   endfunction

endpackage

// File: src/jpt_front.sv
// Front end: accepts text bytes, runs the tokenizer state and forms event groups.
// Depends on jpt_pkg.
module jpt_front #(
   parameter int MAX_NESTING   = jpt_pkg::MAX_NESTING_DEF,
   parameter int POSITION_BITS = jpt_pkg::POSITION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  jpt_pkg::req_type   req_data,
   output logic               grp_valid,
   input  logic               grp_ready,
   output jpt_pkg::group_type grp_data
);

   localparam int DW = $clog2(MAX_NESTING + 1);
   localparam int IW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
   localparam int PW = POSITION_BITS;

   typedef struct packed {
      jpt_pkg::phase_type     phase;
      logic [DW-1:0]          depth;
      logic [MAX_NESTING-1:0] stack;
      logic [PW-1:0]          nb;
      logic [PW-1:0]          nf;
      logic [PW-1:0]          vb;
      logic                   esc;
      logic                   halted;
   } tok_type;

   tok_type       st_ff, st_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic          accept;
   jpt_pkg::group_type grp;

   assign req_ready = grp_ready;
   assign accept    = req_valid && req_ready;

   // walk the byte, then the implied end byte, through the phase machine
   always_comb begin
      tok_type       s;
      logic [1:0]    n;
      logic [7:0]    c;
      logic [PW-1:0] p;
      logic          more, go, inobj, do_fail, do_open, open_obj, open_root;
      logic          do_close, do_emit;
      logic [2:0]    ekind;
      logic [PW-1:0] evf, evp;
      s   = st_ff;
      n   = 2'd0;
      grp = '0;
      c   = 8'd0;
      p   = '0;
      more = 1'b0;
      for (int pass = 0; pass < 2; pass++) begin
         if (pass == 0) begin
            c    = req_data.text_byte;
            p    = pos_ff;
            more = 1'b1;
         end else begin
            c    = jpt_pkg::CH_NUL;
            p    = PW'(pos_ff + 1'b1);
            more = req_data.final_byte && (req_data.text_byte != jpt_pkg::CH_NUL);
         end
         for (int it = 0; it < 4; it++) begin
            go = 1'b0; do_fail = 1'b0; do_open = 1'b0; open_obj = 1'b0;
            open_root = 1'b0; do_close = 1'b0; do_emit = 1'b0;
            ekind = jpt_pkg::EV_END; evf = '0; evp = '0;
            inobj = (s.depth != '0) && (s.depth <= DW'(MAX_NESTING)) &&
                    s.stack[IW'(s.depth - 1'b1)];
            if (more && !s.halted) begin
               unique case (s.phase)
                  jpt_pkg::PH_ROOT: begin
                     if (!jpt_pkg::is_ws(c)) begin
                        if (c == jpt_pkg::CH_LBRACE || c == jpt_pkg::CH_LBRACK) begin
                           do_open   = 1'b1;
                           open_obj  = (c == jpt_pkg::CH_LBRACE);
                           open_root = 1'b1;
                        end else begin
                           do_fail = 1'b1;
                        end
                     end
                  end
                  jpt_pkg::PH_ITEM: begin
                     if (!jpt_pkg::is_ws(c)) begin
                        if (c == jpt_pkg::CH_NUL) begin
                           do_emit  = 1'b1;
                           ekind    = jpt_pkg::EV_END;
                           s.halted = 1'b1;
                        end else if (inobj) begin
                           if (c == jpt_pkg::CH_RBRACE) do_close = 1'b1;
                           else begin
                              s.phase = jpt_pkg::PH_NAME_START;
                              go      = (c != jpt_pkg::CH_COMMA);
                           end
                        end else begin
                           if (c == jpt_pkg::CH_RBRACK) do_close = 1'b1;
                           else begin
                              s.phase = jpt_pkg::PH_VALUE_START;
                              go      = (c != jpt_pkg::CH_COMMA);
                           end
                        end
                     end
                  end
                  jpt_pkg::PH_NAME_START: begin
                     if (!jpt_pkg::is_ws(c)) begin
                        if (c == jpt_pkg::CH_QUOTE) begin
                           s.nb    = PW'(p + 1'b1);
                           s.esc   = 1'b0;
                           s.phase = jpt_pkg::PH_NAME_QUOTED;
                        end else begin
                           s.nb    = p;
                           s.phase = jpt_pkg::PH_NAME_BARE;
                           go      = 1'b1;
                        end
                     end
                  end
                  jpt_pkg::PH_NAME_QUOTED: begin
                     if (c == jpt_pkg::CH_NUL) do_fail = 1'b1;
                     else if (s.esc) s.esc = 1'b0;
                     else if (c == jpt_pkg::CH_BSLASH) s.esc = 1'b1;
                     else if (c == jpt_pkg::CH_QUOTE) begin
                        s.nf    = p;
                        s.phase = jpt_pkg::PH_AFTER_NAME;
                     end
                  end
                  jpt_pkg::PH_NAME_BARE: begin
                     if (c == jpt_pkg::CH_NUL || jpt_pkg::is_ws(c) ||
                         c == jpt_pkg::CH_COLON || c == jpt_pkg::CH_RBRACE ||
                         c == jpt_pkg::CH_RBRACK) begin
                        s.nf    = p;
                        s.phase = jpt_pkg::PH_AFTER_NAME;
                        go      = 1'b1;
                     end
                  end
                  jpt_pkg::PH_AFTER_NAME: begin
                     if (!jpt_pkg::is_ws(c)) begin
                        s.phase = jpt_pkg::PH_VALUE_START;
                        go      = (c != jpt_pkg::CH_COLON);
                     end
                  end
                  jpt_pkg::PH_VALUE_START: begin
                     if (!jpt_pkg::is_ws(c)) begin
                        if (c == jpt_pkg::CH_LBRACE || c == jpt_pkg::CH_LBRACK) begin
                           do_open  = 1'b1;
                           open_obj = (c == jpt_pkg::CH_LBRACE);
                        end else if (c == jpt_pkg::CH_QUOTE) begin
                           s.vb    = PW'(p + 1'b1);
                           s.esc   = 1'b0;
                           s.phase = jpt_pkg::PH_VALUE_QUOTED;
                        end else if (c == jpt_pkg::CH_NUL || c == jpt_pkg::CH_COMMA ||
                                     c == jpt_pkg::CH_RBRACE ||
                                     c == jpt_pkg::CH_RBRACK) begin
                           do_fail = 1'b1;
                        end else begin
                           s.vb    = p;
                           s.phase = jpt_pkg::PH_VALUE_BARE;
                        end
                     end
                  end
                  jpt_pkg::PH_VALUE_QUOTED: begin
                     if (c == jpt_pkg::CH_NUL) do_fail = 1'b1;
                     else if (s.esc) s.esc = 1'b0;
                     else if (c == jpt_pkg::CH_BSLASH) s.esc = 1'b1;
                     else if (c == jpt_pkg::CH_QUOTE) begin
                        do_emit = 1'b1;
                        ekind   = jpt_pkg::EV_STRING;
                        evf     = s.vb;
                        evp     = p;
                        s.phase = jpt_pkg::PH_ITEM;
                     end
                  end
                  jpt_pkg::PH_VALUE_BARE: begin
                     if (c == jpt_pkg::CH_NUL || jpt_pkg::is_ws(c) ||
                         c == jpt_pkg::CH_COMMA || c == jpt_pkg::CH_RBRACE ||
                         c == jpt_pkg::CH_RBRACK) begin
                        do_emit = 1'b1;
                        ekind   = jpt_pkg::EV_SCALAR;
                        evf     = s.vb;
                        evp     = p;
                        s.phase = jpt_pkg::PH_ITEM;
                        go      = 1'b1;
                     end
                  end
                  jpt_pkg::PH_AFTER_ROOT: begin
                     if (!jpt_pkg::is_ws(c)) begin
                        if (c == jpt_pkg::CH_NUL) begin
                           do_emit  = 1'b1;
                           ekind    = jpt_pkg::EV_END;
                           s.halted = 1'b1;
                        end else begin
                           do_fail = 1'b1;
                        end
                     end
                  end
                  default: do_fail = 1'b1;
               endcase

               // push a level or fail on overflow
               if (do_open) begin
                  if (s.depth >= DW'(MAX_NESTING)) begin
                     do_fail = 1'b1;
                  end else begin
                     s.stack[IW'(s.depth)] = open_obj;
                     s.depth  = DW'(s.depth + 1'b1);
                     s.phase  = jpt_pkg::PH_ITEM;
                     do_emit  = 1'b1;
                     ekind    = open_obj ? jpt_pkg::EV_OBJECT : jpt_pkg::EV_ARRAY;
                  end
               end
               // pop a level
               if (do_close) begin
                  if (s.depth != '0) s.depth = DW'(s.depth - 1'b1);
                  s.phase = (s.depth != '0) ? jpt_pkg::PH_ITEM : jpt_pkg::PH_AFTER_ROOT;
                  do_emit = 1'b1;
                  ekind   = jpt_pkg::EV_CLOSE;
               end
               if (do_fail) begin
                  do_emit  = 1'b1;
                  ekind    = jpt_pkg::EV_INVALID;
                  s.halted = 1'b1;
               end
               // record the event
               if (do_emit) begin
                  grp.evs[n].event_kind = ekind;
                  if ((ekind == jpt_pkg::EV_STRING || ekind == jpt_pkg::EV_SCALAR) && inobj
                      || (do_open && !do_fail && !open_root && inobj)) begin
                     grp.evs[n].has_name   = 1'b1;
                     grp.evs[n].name_first = 16'(s.nb);
                     grp.evs[n].name_past  = 16'(s.nf);
                  end
                  grp.evs[n].value_first = 16'(evf);
                  grp.evs[n].value_past  = 16'(evp);
                  grp.evs[n].level       = 5'(s.depth);
                  n = 2'(n + 1'b1);
               end
            end
            more = go;
         end
      end
      if (n != 2'd0) grp.evs[2'(n - 1'b1)].run_end = 1'b1;
      grp.count = n;
      st_in     = s;
      pos_in    = PW'(pos_ff + 1'b1);
   end

   assign grp_valid = accept && (grp.count != 2'd0);
   assign grp_data  = grp;

   // advance state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.phase  <= jpt_pkg::PH_ROOT;
         st_ff.depth  <= '0;
         st_ff.stack  <= '0;
         st_ff.nb     <= '0;
         st_ff.nf     <= '0;
         st_ff.vb     <= '0;
         st_ff.esc    <= 1'b0;
         st_ff.halted <= 1'b0;
         pos_ff       <= '0;
      end else if (accept) begin
         st_ff  <= st_in;
         pos_ff <= pos_in;
      end
   end

endmodule

// File: src/jpt_back.sv
// Back end: queues event groups and delivers their events one beat at a time.
// Depends on jpt_pkg.
module jpt_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               grp_valid,
   output logic               grp_ready,
   input  jpt_pkg::group_type grp_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output jpt_pkg::rsp_type   rsp_data
);

   localparam int QD = jpt_pkg::QUEUE_DEPTH;
   localparam int QW = $clog2(QD);

   jpt_pkg::group_type   queue_ff [QD];
   logic [QW-1:0]        wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QW:0]          cnt_ff, cnt_in;
   logic [1:0]           idx_ff, idx_in;
   jpt_pkg::group_type   head;
   logic                 pop;

   assign grp_ready = (cnt_ff != (QW+1)'(QD));
   assign head      = queue_ff[rptr_ff];
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = head.evs[idx_ff];

   // step through the head group, drop it after its last event
   always_comb begin
      pop    = 1'b0;
      idx_in = idx_ff;
      if (rsp_valid && rsp_ready) begin
         if (idx_ff == 2'(head.count - 1'b1)) begin
            pop    = 1'b1;
            idx_in = 2'd0;
         end else begin
            idx_in = 2'(idx_ff + 1'b1);
         end
      end
      wptr_in = grp_valid ? QW'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in = pop ? QW'(rptr_ff + 1'b1) : rptr_ff;
      cnt_in  = (QW+1)'(cnt_ff + (grp_valid ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
         idx_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
         idx_ff  <= idx_in;
      end
   end

   // hold group payloads
   always_ff @(posedge clock) begin
      if (grp_valid) queue_ff[wptr_ff] <= grp_data;
   end

endmodule

// File: src/json_pull_tokenizer_core.sv
// Top level of the JSON pull tokenizer: front end, group queue and back end.
// Depends on jpt_pkg, jpt_front and jpt_back.
//
//   channel  direction  payload              handshake
//   req      in         jpt_pkg::req_type    req_valid / req_ready
//   rsp      out        jpt_pkg::rsp_type    rsp_valid / rsp_ready
//
// One byte is accepted per cycle while the four-entry group queue has room.
// Each byte gives zero to three events; the back end sends one event per cycle
// while rsp_ready is high. The events of a byte are registered in the group
// queue before the back end sends them. Reset is synchronous and clears the
// parse state, the offset counter and the queue at once.
module json_pull_tokenizer_core #(
   parameter int MAX_NESTING   = jpt_pkg::MAX_NESTING_DEF,
   parameter int POSITION_BITS = jpt_pkg::POSITION_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jpt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jpt_pkg::rsp_type rsp_data
);

   logic               grp_valid, grp_ready;
   jpt_pkg::group_type grp_data;

   jpt_front #(
      .MAX_NESTING  (MAX_NESTING),
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .grp_valid(grp_valid),
      .grp_ready(grp_ready),
      .grp_data (grp_data)
   );

   jpt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .grp_valid(grp_valid),
      .grp_ready(grp_ready),
      .grp_data (grp_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // rest of a group follows without a gap
   a_group_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.run_end |=> rsp_valid)
      else $error("event group broken");

   // unnamed events carry no name offsets
   a_no_name: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_name |->
         rsp_data.name_first == 16'd0 && rsp_data.name_past == 16'd0)
      else $error("name offsets on unnamed event");

   // only string and scalar events carry value offsets
   a_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind != jpt_pkg::EV_STRING &&
         rsp_data.event_kind != jpt_pkg::EV_SCALAR |->
         rsp_data.value_first == 16'd0 && rsp_data.value_past == 16'd0)
      else $error("value offsets on structural event");

   // a group is only pushed while the queue has room
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      grp_valid |-> grp_ready)
      else $error("group pushed into full queue");

endmodule
